@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned OpW          = 2;
  localparam int unsigned InW          = 32;
  localparam int unsigned MagW         = 64;
  localparam int unsigned DenW         = 31;
  localparam int unsigned StatW        = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Request payload.
  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic signed [InW-1:0] a_numerator;
    logic signed [InW-1:0] a_denominator;
    logic signed [InW-1:0] b_numerator;
    logic signed [InW-1:0] b_denominator;
  } req_t;

  // Classified work item handed from front end to back end.
  typedef struct packed {
    logic            err;    // zero denominator or divisor
    logic            zero;   // numerator is zero
    logic            neg;    // sign of the result
    logic [MagW-1:0] nmag;
    logic [MagW-1:0] dmag;
  } work_t;

  // Result payload.
  typedef struct packed {
    logic signed [InW-1:0] result_numerator;
    logic [DenW-1:0]       result_denominator;
    logic [StatW-1:0]      status;
  } res_t;

  function automatic logic [InW-1:0] mag32(input logic [InW-1:0] x);
    return x[InW-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ rtl/rau_if.sv @@
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface rau_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the reduced result with a status.
// ----------------------------------------------------------------------------
// One item at a time runs through the back end: a data-dependent binary gcd
// over the 64-bit magnitudes followed by two bit-serial divisions by the gcd
// and a range check; an item with an error or a zero numerator skips straight
// to the result register.
// The front end forms the cross products on one shared 32x32 multiplier and
// can hold up to two finished items in its queue meanwhile.
// The result register holds its final value from the first cycle it shows
// valid until it is transferred.
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input logic clk_i,
  input logic rst_ni,
  rau_if.sink   req_i,
  rau_if.source res_o
);
  import rau_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready, o_valid;
  work_t f_data, b_data;

  rau_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req_i.valid), .in_ready_o (req_i.ready), .in_data_i (req_i.data),
    .wk_valid_o (f_valid), .wk_ready_i (f_ready), .wk_data_o (f_data)
  );

  rau_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid), .in_ready_o (f_ready), .in_data_i (f_data),
    .out_valid_o (b_valid), .out_ready_i (b_ready), .out_data_o (b_data)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .wk_valid_i (b_valid), .wk_ready_o (b_ready), .wk_data_i (b_data),
    .res_valid_o (o_valid), .res_ready_i (res_o.ready), .res_data_o (res_o.data)
  );

  assign res_o.valid = o_valid;

`ifndef NO_ASSERTIONS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.data.status == ST_OK || res_o.data.status == ST_ZERO_DEN ||
                     res_o.data.status == ST_OVERFLOW)) else $error("bad status");
  a_err_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.status != ST_OK) |-> res_o.data.result_denominator == '0)
    else $error("error result not 0/0");
  a_q_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && b_ready) |=> !b_ready) else $error("back end took two items");
`endif
endmodule

@@ rtl/rau_front.sv @@
// ----------------------------------------------------------------------------
// rau_front
// Takes a request, forms the cross products in turn with a shared 32x32
// multiplier, combines them and classifies the item.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::req_t  in_data_i,
  output logic           wk_valid_o,
  input  logic           wk_ready_i,
  output rau_pkg::work_t wk_data_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_M1   = 4'b0010,
    S_M2   = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [InW-1:0]  man_q, mad_q, mbn_q, mbd_q;
  logic            san_q, sad_q, sbn_q, sbd_q;
  logic [OpW-1:0]  op_q;
  logic            err_q;
  logic [MagW-1:0] p1_q, p2_q, p3_q;
  logic [InW-1:0]  mul_a, mul_b;
  logic [MagW-1:0] prod;
  logic            s1, s2, ns, ds;
  logic [MagW-1:0] nmag, dmag;
  logic            busy_q;   // operands loaded, products pending

  assign prod = MagW'(mul_a) * MagW'(mul_b);

  // Multiplier operands by step: first numerator term, then second, then den.
  always_comb begin
    mul_a = mad_q;
    mul_b = mbd_q;
    case (state_q)
      S_IDLE: begin
        mul_a = man_q;
        mul_b = (op_q == OP_MUL) ? mbn_q : mbd_q;
      end
      S_M1: begin
        mul_a = mbn_q;
        mul_b = mad_q;
      end
      S_M2: begin
        mul_a = mad_q;
        mul_b = (op_q == OP_DIV) ? mbn_q : mbd_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    s1   = san_q ^ ((op_q == OP_MUL) ? sbn_q : sbd_q);
    s2   = sbn_q ^ sad_q ^ (op_q == OP_SUB);
    ds   = sad_q ^ ((op_q == OP_DIV) ? sbn_q : sbd_q);
    dmag = p3_q;
    if (op_q == OP_MUL || op_q == OP_DIV) begin
      nmag = p1_q;
      ns   = s1;
    end else if (s1 == s2) begin
      nmag = p1_q + p2_q;
      ns   = s1;
    end else if (p1_q >= p2_q) begin
      nmag = p1_q - p2_q;
      ns   = s1;
    end else begin
      nmag = p2_q - p1_q;
      ns   = s2;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !busy_q;
  assign wk_valid_o = (state_q == S_OUT);
  assign wk_data_o  = '{err: err_q, zero: (nmag == '0), neg: ns ^ ds,
                        nmag: nmag, dmag: dmag};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (busy_q) state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_OUT;
      S_OUT:   if (wk_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) busy_q <= 1'b1;
      else if (state_q == S_IDLE) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= in_data_i.operation;
      man_q <= mag32(in_data_i.a_numerator);
      mad_q <= mag32(in_data_i.a_denominator);
      mbn_q <= mag32(in_data_i.b_numerator);
      mbd_q <= mag32(in_data_i.b_denominator);
      san_q <= in_data_i.a_numerator[InW-1];
      sad_q <= in_data_i.a_denominator[InW-1];
      sbn_q <= in_data_i.b_numerator[InW-1];
      sbd_q <= in_data_i.b_denominator[InW-1];
      err_q <= (in_data_i.a_denominator == '0) || (in_data_i.b_denominator == '0) ||
               ((in_data_i.operation == OP_DIV) && (in_data_i.b_numerator == '0));
    end
    case (state_q)
      S_IDLE:  if (busy_q) p1_q <= prod;
      S_M1:    p2_q <= prod;
      S_M2:    p3_q <= prod;
      default: ;
    endcase
  end
endmodule

@@ rtl/rau_queue.sv @@
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::work_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::work_t out_data_o
);
  import rau_pkg::*;

  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule

@@ rtl/rau_back.sv @@
// ----------------------------------------------------------------------------
// rau_back
// Binary gcd of both magnitudes, bit-serial division of both by the gcd,
// range check and output register; error or zero items go straight out.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wk_valid_i,
  output logic           wk_ready_o,
  input  rau_pkg::work_t wk_data_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rau_pkg::res_t  res_data_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(MagW + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GCD  = 7'b0000010,
    S_SHFT = 7'b0000100,
    S_DIVN = 7'b0001000,
    S_DIVD = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  work_t           w_q;
  logic [MagW-1:0] u_q, v_q, g_q;
  logic [CntW-1:0] k_q, cnt_q;
  logic [MagW-1:0] quo_q, rem_q, nq_q;
  logic [MagW:0]   rtry;
  logic [MagW-1:0] rsh;
  logic [MagW-1:0] lim;
  logic            ovf;
  res_t            res_q;

  assign lim = MagW'(1) << (WIDTH - 1);

  // Restoring division step on the current dividend bit.
  assign rsh  = {rem_q[MagW-2:0], quo_q[MagW-1]};
  assign rtry = {1'b0, rsh} - {1'b0, g_q};

  assign ovf = (quo_q > lim - 1) || (w_q.neg ? (nq_q > lim) : (nq_q > lim - 1));

  assign wk_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (wk_valid_i) state_d = S_GCD;
      S_GCD: begin
        if (w_q.err || w_q.zero) state_d = S_OUT;
        else if (u_q == v_q) state_d = S_SHFT;
      end
      S_SHFT:  state_d = S_DIVN;
      S_DIVN:  if (cnt_q == CntW'(MagW - 1)) state_d = S_DIVD;
      S_DIVD:  if (cnt_q == CntW'(MagW - 1)) state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_OUT:   if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        w_q <= wk_data_i;
        u_q <= wk_data_i.nmag;
        v_q <= wk_data_i.dmag;
        k_q <= '0;
      end
      S_GCD: begin
        // Stein's step: strip common twos, then subtract.
        if (w_q.err) begin
          res_q <= '{result_numerator: '0, result_denominator: '0, status: ST_ZERO_DEN};
        end else if (w_q.zero) begin
          res_q <= '{result_numerator: '0, result_denominator: DenW'(1), status: ST_OK};
        end else if (u_q != v_q) begin
          if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q > v_q) begin
            u_q <= (u_q - v_q) >> 1;
          end else begin
            v_q <= (v_q - u_q) >> 1;
          end
        end
      end
      S_SHFT: begin
        g_q   <= u_q << k_q;
        quo_q <= w_q.nmag;
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIVN, S_DIVD: begin
        if (cnt_q == CntW'(MagW - 1)) begin
          cnt_q <= '0;
          if (state_q == S_DIVN) begin
            // Park the numerator quotient and start on the denominator.
            nq_q  <= {quo_q[MagW-2:0], !rtry[MagW]};
            quo_q <= w_q.dmag;
            rem_q <= '0;
          end else begin
            quo_q <= {quo_q[MagW-2:0], !rtry[MagW]};
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          if (!rtry[MagW]) begin
            rem_q <= rtry[MagW-1:0];
            quo_q <= {quo_q[MagW-2:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[MagW-2:0], 1'b0};
          end
        end
      end
      S_FIN: begin
        res_q <= ovf ? '{result_numerator: '0, result_denominator: '0,
                         status: ST_OVERFLOW}
                     : '{result_numerator: InW'(w_q.neg ? (~nq_q + 1'b1) : nq_q),
                         result_denominator: DenW'(quo_q), status: ST_OK};
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule

@@ test/rau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Watches the request and result channels of the rational arithmetic unit,
// computes the reduced fraction for every request transfer and compares
// each result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rau_checker #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  rau_if       req_i,
  rau_if       res_i,
  output int   mismatch_count_o,
  output int   outstanding_o
);
  import rau_pkg::*;

  res_t expected_fractions[$];

  function automatic logic [MagW-1:0] gcd_mag(input logic [MagW-1:0] x,
                                              input logic [MagW-1:0] y);
    logic [MagW-1:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [MagW-1:0] abs_ext(input logic [InW-1:0] x);
    logic [InW-1:0] m;
    m = x[InW-1] ? (~x + 1'b1) : x;
    return {{(MagW-InW){1'b0}}, m};
  endfunction

  function automatic res_t reduce_fraction(input req_t r);
    res_t            y;
    op_e             op;
    logic            san, sad, sbn, sbd, ns, ds, s1, s2;
    logic [MagW-1:0] man, mad, mbn, mbd, m1, m2, nmag, dmag, g, lim;
    op  = op_e'(r.operation);
    san = r.a_numerator[InW-1];
    sad = r.a_denominator[InW-1];
    sbn = r.b_numerator[InW-1];
    sbd = r.b_denominator[InW-1];
    man = abs_ext(r.a_numerator);
    mad = abs_ext(r.a_denominator);
    mbn = abs_ext(r.b_numerator);
    mbd = abs_ext(r.b_denominator);
    lim = 64'd1 << (WIDTH - 1);
    y   = '0;
    if (mad == 0 || mbd == 0 || (op == OP_DIV && mbn == 0)) begin
      y.status = ST_ZERO_DEN;
      return y;
    end
    case (op)
      OP_ADD, OP_SUB: begin
        s1 = san ^ sbd;
        s2 = sbn ^ sad ^ (op == OP_SUB);
        m1 = man * mbd;
        m2 = mbn * mad;
        if (s1 == s2) begin
          nmag = m1 + m2;
          ns   = s1;
        end else if (m1 >= m2) begin
          nmag = m1 - m2;
          ns   = s1;
        end else begin
          nmag = m2 - m1;
          ns   = s2;
        end
        dmag = mad * mbd;
        ds   = sad ^ sbd;
      end
      OP_MUL: begin
        nmag = man * mbn;
        ns   = san ^ sbn;
        dmag = mad * mbd;
        ds   = sad ^ sbd;
      end
      default: begin
        nmag = man * mbd;
        ns   = san ^ sbd;
        dmag = mad * mbn;
        ds   = sad ^ sbn;
      end
    endcase
    if (nmag == 0) begin
      y.result_denominator = DenW'(1);
      y.status             = ST_OK;
      return y;
    end
    g    = gcd_mag(nmag, dmag);
    nmag = nmag / g;
    dmag = dmag / g;
    ns   = ns ^ ds;
    if (dmag > lim - 1 || (ns ? (nmag > lim) : (nmag > lim - 1))) begin
      y.status = ST_OVERFLOW;
      return y;
    end
    nmag                 = ns ? (~nmag + 1'b1) : nmag;
    y.result_numerator   = nmag[InW-1:0];
    y.result_denominator = dmag[DenW-1:0];
    y.status             = ST_OK;
    return y;
  endfunction

  assign outstanding_o = expected_fractions.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      expected_fractions.delete();
      mismatch_count_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_fractions.push_back(reduce_fraction(req_i.data));
      end
      if (res_i.valid && res_i.ready) begin
        got = res_i.data;
        if (expected_fractions.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d status %0d", $time,
                   $signed(got.result_numerator), got.result_denominator,
                   got.status);
          mismatch_count_o++;
        end else begin
          want = expected_fractions.pop_front();
          if (got.result_numerator !== want.result_numerator) begin
            $display("%0t: numerator expected %0d actual %0d", $time,
                     $signed(want.result_numerator), $signed(got.result_numerator));
            mismatch_count_o++;
          end
          if (got.result_denominator !== want.result_denominator) begin
            $display("%0t: denominator expected %0d actual %0d", $time,
                     want.result_denominator, got.result_denominator);
            mismatch_count_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
            mismatch_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction operations into the rational
// arithmetic unit with random gaps and stalls; the checker does the
// comparison and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned Width       = 32;
  localparam int          NumRandom   = 1830;
  localparam longint      CycleLimit  = 3000000;
  localparam int          DrainCycles = 400;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   outstanding;
  longint cycle_count;

  rau_if #(.payload_t(req_t)) req_if ();
  rau_if #(.payload_t(res_t)) res_if ();

  rational_arithmetic_unit #(.WIDTH(Width)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  rau_checker #(.WIDTH(Width)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .res_i           (res_if),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($signed($urandom_range(0, 40)) - 20);
    if (r < 65) return 32'($signed($urandom_range(0, 4000)) - 2000);
    if (r < 75) return 32'($signed($urandom_range(0, 200000)) - 100000);
    if (r < 88) return $urandom();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd1;
      4: return 32'h8000_0001;
      default: return 32'd0;
    endcase
  endfunction

  // After each transfer, drop result ready for a randomly picked gap, which may be zero.
  int result_stall;

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) result_stall = pick_gap();
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready = 1'b0;
    end else if (result_stall > 0) begin
      result_stall--;
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  task automatic send_fraction_op(input op_e op, input logic [31:0] an,
                                  input logic [31:0] ad, input logic [31:0] bn,
                                  input logic [31:0] bd);
    req_t r;
    int   gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r.operation     = op;
    r.a_numerator   = an;
    r.a_denominator = ad;
    r.b_numerator   = bn;
    r.b_denominator = bd;
    req_if.data  = r;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    op_e op;
    cycle_count    = 0;
    result_stall   = 0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    res_if.ready   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: each operation, zero denominators, zero divisor, zero result,
    // sign on the denominator, extremes and overflow.
    send_fraction_op(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction_op(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_fraction_op(OP_MUL, 32'd6, 32'd4, -32'd2, 32'd9);
    send_fraction_op(OP_DIV, 32'd3, 32'd7, 32'd9, -32'd14);
    send_fraction_op(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
    send_fraction_op(OP_MUL, 32'd5, 32'd1, 32'd1, 32'd0);
    send_fraction_op(OP_DIV, 32'd5, 32'd3, 32'd0, 32'd7);
    send_fraction_op(OP_MUL, 32'd0, -32'd5, 32'd7, 32'd3);
    send_fraction_op(OP_SUB, -32'd1, -32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_MUL, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_DIV, 32'd1, 32'd1, 32'd1, 32'h8000_0000);
    send_fraction_op(OP_DIV, 32'd1, 32'd1, -32'd1, 32'h8000_0000);
    send_fraction_op(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff);
    send_fraction_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000);
    send_fraction_op(OP_DIV, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_ffff,
                     32'h7fff_ffff);
    send_fraction_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff);
    send_fraction_op(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000);

    for (int i = 0; i < NumRandom; i++) begin
      op = op_e'($urandom_range(0, 3));
      send_fraction_op(op, pick_operand(), pick_operand(), pick_operand(),
                       pick_operand());
    end
    req_if.valid = 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("rational_arithmetic_unit verification clean");
    end else begin
      $display("rational_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
test/rau_checker.sv
test/tb_rational_arithmetic_unit.sv
